>>> rtl/voxel_grid_ray_walk_unit_defines.svh
// ---------------------------------------------------------------------------
// voxel grid ray walk assertion macros
// shared assertion forms used by the checker of the walk unit
// ---------------------------------------------------------------------------
`ifndef VOXEL_GRID_RAY_WALK_UNIT_DEFINES_SVH
`define VOXEL_GRID_RAY_WALK_UNIT_DEFINES_SVH

// same-cycle implication
`define VGRW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VGRW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vgrw_pkg.sv
// ---------------------------------------------------------------------------
// vgrw_pkg
// types, codes and saturation helper of the voxel grid ray walk unit
// ---------------------------------------------------------------------------
`default_nettype none

package vgrw_pkg;

    // width of one cell count field in grid_dims
    localparam int AXIS_BITS = 10;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_ADV   = 1'b1;

    localparam logic [2:0] ST_VISIT   = 3'd0;
    localparam logic [2:0] ST_HIT     = 3'd1;
    localparam logic [2:0] ST_MISS    = 3'd2;
    localparam logic [2:0] ST_NO_GRID = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic [1:0] STEP_NONE  = 2'd0;
    localparam logic [1:0] STEP_PLUS  = 2'd1;
    localparam logic [1:0] STEP_MINUS = 2'd2;

    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic [30:0]        NO_HIT = 31'h7FFF_FFFF;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [30:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'(MAX32)) begin
            r = MAX32;
        end else if (v < 66'(MIN32)) begin
            r = MIN32;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/vgrw_div.sv
// ---------------------------------------------------------------------------
// vgrw_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module vgrw_div
    import vgrw_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_div_req  i_req,
    output t_div_rsp  o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [30:0] r_den;
    logic [31:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem[30:0], r_quo[31]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

`default_nettype wire

>>> rtl/vgrw_mul.sv
// ---------------------------------------------------------------------------
// vgrw_mul
// shared signed multiplier with registered product and fixed point result
// ---------------------------------------------------------------------------
`default_nettype none

module vgrw_mul
    import vgrw_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire                      i_clk,
    input  wire  signed [32:0]       i_a,
    input  wire  signed [32:0]       i_b,
    output logic signed [65:0]       o_raw,
    output logic signed [31:0]       o_q
);

    logic signed [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // arithmetic shift floors toward minus infinity
    assign o_raw = r_prod;
    assign o_q   = sat32(r_prod >>> FRAC_BITS);

endmodule

`default_nettype wire

>>> rtl/voxel_grid_ray_walk_unit.sv
// ---------------------------------------------------------------------------
// voxel_grid_ray_walk_unit
// steps a fixed point ray through a uniform 3d voxel grid, one cell per beat
// ---------------------------------------------------------------------------
// A start beat (tuser 0) loads origin, direction, reciprocal direction and
// start distance; the unit finds the clamped start cell, the per-axis
// crossing distances and increments, and answers with the cell index and
// the distance at which the ray leaves that cell. Each advance beat (tuser 1)
// carries the closest hit so far: a hit at or before the exit distance ends
// the walk with a hit, otherwise the unit steps the axis with the least
// crossing and reports the new cell, or a miss when it leaves the grid.
// One beat is taken at a time and s_axis_tready is low while it is in work.
// All math runs through one registered multiplier and one bit-serial
// divider under a small sequencer. In a start beat the divide for the
// start cell dominates the work on each axis; an advance beat that steps
// runs three multiplies for the cell index, while hit, miss, no-grid and
// ignored answers go straight to the output. The result sits in an output
// register, so a new beat is taken while it waits.
// ---------------------------------------------------------------------------
`default_nettype none

module voxel_grid_ray_walk_unit
    import vgrw_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // apb register port
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // ray beats in
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // origin_x,y,z, dir_x,y,z, inv_dir_x,y,z, start_distance, hit_distance, pad
    input  wire  [351:0] s_axis_tdata,
    // command
    input  wire          s_axis_tuser,
    // results out
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // cell_index, exit_distance, pad
    output logic [63:0]  m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser
);

    localparam int DW = 3 * AXIS_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MT   = 4'd1;
    localparam logic [3:0] S_P    = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_MQ   = 4'd4;
    localparam logic [3:0] S_FACE = 4'd5;
    localparam logic [3:0] S_MC   = 4'd6;
    localparam logic [3:0] S_MD   = 4'd7;
    localparam logic [3:0] S_MX   = 4'd8;
    localparam logic [3:0] S_I1   = 4'd9;
    localparam logic [3:0] S_I2   = 4'd10;
    localparam logic [3:0] S_I3   = 4'd11;
    localparam logic [3:0] S_I4   = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    localparam logic [2:0] REG_MIN_X  = 3'd0;
    localparam logic [2:0] REG_MIN_Y  = 3'd1;
    localparam logic [2:0] REG_MIN_Z  = 3'd2;
    localparam logic [2:0] REG_SIZE_X = 3'd3;
    localparam logic [2:0] REG_SIZE_Y = 3'd4;
    localparam logic [2:0] REG_SIZE_Z = 3'd5;
    localparam logic [2:0] REG_DIMS   = 3'd6;

    // configuration registers
    logic signed [31:0] r_gmin [3];
    logic [30:0]        r_csize [3];
    logic [29:0]        r_grid_dims;

    // walk state
    logic                 r_walk;
    logic [AXIS_BITS-1:0] r_pos [3];
    logic [1:0]           r_step [3];
    logic signed [31:0]   r_nc [3];
    logic signed [31:0]   r_dl [3];
    logic [29:0]          r_idx;
    logic signed [31:0]   r_exit;

    // latched start beat
    logic signed [31:0] r_org [3];
    logic signed [31:0] r_dir [3];
    logic signed [31:0] r_inv [3];
    logic signed [31:0] r_tmin;

    // sequencer
    logic [3:0]         r_state, n_state;
    logic [1:0]         r_axis;
    logic [31:0]        r_q;
    logic signed [31:0] r_off;
    logic [29:0]        r_nxny;
    logic [29:0]        r_acc;

    // pending result and output register
    logic [2:0]         r_res_st;
    logic [29:0]        r_res_idx;
    logic signed [31:0] r_res_ex;
    logic               r_ovalid;
    logic [2:0]         r_out_st;
    logic [29:0]        r_out_idx;
    logic signed [31:0] r_out_ex;

    // apb port
    logic       w_wr;
    logic [2:0] w_ridx;

    assign pready = 1'b1;
    assign w_ridx = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_gmin[a]  <= '0;
                r_csize[a] <= 31'd65536;
            end
            r_grid_dims <= '0;
        end else if (w_wr) begin
            unique case (w_ridx)
                REG_MIN_X:  r_gmin[0]   <= pwdata;
                REG_MIN_Y:  r_gmin[1]   <= pwdata;
                REG_MIN_Z:  r_gmin[2]   <= pwdata;
                REG_SIZE_X: r_csize[0]  <= pwdata[30:0];
                REG_SIZE_Y: r_csize[1]  <= pwdata[30:0];
                REG_SIZE_Z: r_csize[2]  <= pwdata[30:0];
                REG_DIMS:   r_grid_dims <= pwdata[29:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_ridx)
            REG_MIN_X:  prdata = r_gmin[0];
            REG_MIN_Y:  prdata = r_gmin[1];
            REG_MIN_Z:  prdata = r_gmin[2];
            REG_SIZE_X: prdata = {1'b0, r_csize[0]};
            REG_SIZE_Y: prdata = {1'b0, r_csize[1]};
            REG_SIZE_Z: prdata = {1'b0, r_csize[2]};
            REG_DIMS:   prdata = {2'b00, r_grid_dims};
            default:    prdata = '0;
        endcase
    end

    // grid counts per axis from the current register value
    logic [DW-1:0]        w_dims;
    logic [AXIS_BITS-1:0] w_n [3];
    logic                 w_no_grid;

    assign w_dims = DW'(r_grid_dims);
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_n[a] = w_dims[a*AXIS_BITS +: AXIS_BITS];
        end
    end
    assign w_no_grid = (w_n[0] == '0) || (w_n[1] == '0) || (w_n[2] == '0);

    // input beat
    logic        w_in_acc;
    logic        w_cmd;
    logic [30:0] w_hd;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = s_axis_tuser;
    assign w_hd          = s_axis_tdata[350:320];

    // axis with the least crossing: x only when strictly below both
    logic [1:0] w_ax;
    always_comb begin
        if (r_nc[0] < r_nc[1]) begin
            w_ax = (r_nc[0] < r_nc[2]) ? 2'd0 : 2'd2;
        end else begin
            w_ax = (r_nc[1] < r_nc[2]) ? 2'd1 : 2'd2;
        end
    end

    // one selected axis: the start sequence walks r_axis, an advance uses w_ax
    logic [1:0]           w_sel;
    logic [AXIS_BITS-1:0] w_pos_s;
    logic [1:0]           w_step_s;
    logic [AXIS_BITS-1:0] w_n_s;
    logic signed [31:0]   w_org_s, w_dir_s, w_inv_s, w_gmin_s;
    logic [30:0]          w_sz_s;

    assign w_sel    = (r_state == S_IDLE) ? w_ax : r_axis;
    assign w_pos_s  = r_pos[w_sel];
    assign w_step_s = r_step[w_sel];
    assign w_n_s    = w_n[w_sel];
    assign w_org_s  = r_org[w_sel];
    assign w_dir_s  = r_dir[w_sel];
    assign w_inv_s  = r_inv[w_sel];
    assign w_gmin_s = r_gmin[w_sel];
    // a zero cell size is taken as one
    assign w_sz_s   = (r_csize[w_sel] == '0) ? 31'd1 : r_csize[w_sel];

    // advance decision
    logic [AXIS_BITS:0] w_np;
    logic               w_is_hit;
    logic               w_leave;

    always_comb begin
        unique case (w_step_s)
            STEP_PLUS:  w_np = {1'b0, w_pos_s} + 1'b1;
            STEP_MINUS: w_np = {1'b0, w_pos_s} - 1'b1;
            default:    w_np = {1'b0, w_pos_s};
        endcase
    end
    assign w_is_hit = (w_hd != NO_HIT) && ($signed({1'b0, w_hd}) <= r_exit);
    // a step below zero wraps to the top bit, which the bound test also catches
    assign w_leave  = (w_step_s == STEP_NONE) || (w_np >= {1'b0, w_n_s});

    // shared multiplier
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mraw;
    logic signed [31:0] w_mq;

    always_comb begin
        unique case (r_state)
            S_MT: begin
                w_ma = 33'(r_tmin);
                w_mb = 33'(w_dir_s);
            end
            S_MQ: begin
                w_ma = $signed({1'b0, r_q});
                w_mb = $signed({2'b00, w_sz_s});
            end
            S_MC: begin
                w_ma = 33'(r_off);
                w_mb = 33'(w_inv_s);
            end
            S_MD: begin
                w_ma = $signed({2'b00, w_sz_s});
                w_mb = 33'(w_inv_s);
            end
            S_I1: begin
                w_ma = $signed(33'(w_n[0]));
                w_mb = $signed(33'(w_n[1]));
            end
            S_I2: begin
                w_ma = $signed(33'(r_pos[1]));
                w_mb = $signed(33'(w_n[0]));
            end
            S_I3: begin
                w_ma = $signed(33'(r_pos[2]));
                w_mb = $signed({3'b000, r_nxny});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    vgrw_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_raw (w_mraw),
        .o_q   (w_mq)
    );

    // start point and offset into the grid
    logic signed [31:0] w_p;
    logic signed [33:0] w_diff;

    assign w_p    = (r_tmin > 0) ? sat32(66'(w_org_s) + 66'(w_mq)) : w_org_s;
    assign w_diff = 34'(w_p) - 34'(w_gmin_s);

    // shared divider
    t_div_req w_dreq;
    t_div_rsp w_drsp;

    assign w_dreq.start = (r_state == S_P) && !w_diff[33];
    assign w_dreq.num   = w_diff[31:0];
    assign w_dreq.den   = w_sz_s;

    vgrw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // cell face offset from the origin
    logic signed [65:0] w_face;
    assign w_face = 66'(w_gmin_s) + w_mraw - 66'(w_org_s)
                  + ((w_dir_s > 0) ? $signed({35'd0, w_sz_s}) : 66'sd0);

    // least crossing, used as exit distance
    logic signed [31:0] w_min01, w_least;
    assign w_min01 = (r_nc[1] < r_nc[0]) ? r_nc[1] : r_nc[0];
    assign w_least = (r_nc[2] < w_min01) ? r_nc[2] : w_min01;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_cmd == CMD_START) begin
                        n_state = w_no_grid ? S_OUT : S_MT;
                    end else if (!r_walk || w_is_hit || w_leave) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_I1;
                    end
                end
            end
            S_MT:   n_state = S_P;
            S_P:    n_state = w_diff[33] ? S_MQ : S_DIV;
            S_DIV:  n_state = w_drsp.done ? S_MQ : S_DIV;
            S_MQ: begin
                if (w_dir_s == 0) begin
                    n_state = (r_axis == 2'd2) ? S_I1 : S_MT;
                end else begin
                    n_state = S_FACE;
                end
            end
            S_FACE: n_state = S_MC;
            S_MC:   n_state = S_MD;
            S_MD:   n_state = S_MX;
            S_MX:   n_state = (r_axis == 2'd2) ? S_I1 : S_MT;
            S_I1:   n_state = S_I2;
            S_I2:   n_state = S_I3;
            S_I3:   n_state = S_I4;
            S_I4:   n_state = S_OUT;
            S_OUT:  n_state = (!r_ovalid || m_axis_tready) ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_axis   <= '0;
            r_walk   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_pos[a]  <= '0;
                r_step[a] <= STEP_NONE;
                r_nc[a]   <= '0;
                r_dl[a]   <= '0;
            end
            r_idx  <= '0;
            r_exit <= '0;
        end else begin
            r_state <= n_state;

            // a new result loads in the same cycle the old one leaves
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_axis <= '0;
                    if (w_in_acc) begin
                        if (w_cmd == CMD_START) begin
                            // a new start drops any walk in progress
                            r_walk <= 1'b0;
                        end else if (r_walk) begin
                            if (w_is_hit || w_leave) begin
                                r_walk <= 1'b0;
                            end else begin
                                r_pos[w_ax] <= w_np[AXIS_BITS-1:0];
                                r_nc[w_ax]  <= sat32(66'(r_nc[w_ax]) + 66'(r_dl[w_ax]));
                            end
                        end
                    end
                end
                S_MQ: begin
                    if (w_dir_s == 0) begin
                        r_pos[r_axis]  <= r_q[AXIS_BITS-1:0];
                        r_step[r_axis] <= STEP_NONE;
                        r_nc[r_axis]   <= MAX32;
                        r_dl[r_axis]   <= '0;
                        r_axis         <= r_axis + 2'd1;
                    end
                end
                S_MD: begin
                    r_nc[r_axis] <= w_mq;
                end
                S_MX: begin
                    r_pos[r_axis] <= r_q[AXIS_BITS-1:0];
                    if (w_dir_s > 0) begin
                        r_step[r_axis] <= STEP_PLUS;
                        r_dl[r_axis]   <= w_mq;
                    end else begin
                        r_step[r_axis] <= STEP_MINUS;
                        r_dl[r_axis]   <= sat32(-66'(w_mq));
                    end
                    r_axis <= r_axis + 2'd1;
                end
                S_I4: begin
                    r_idx  <= 30'(r_pos[0]) + r_acc + w_mraw[29:0];
                    r_exit <= w_least;
                    r_walk <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc) begin
            for (int a = 0; a < 3; a++) begin
                r_org[a] <= s_axis_tdata[a*32 +: 32];
                r_dir[a] <= s_axis_tdata[96 + a*32 +: 32];
                r_inv[a] <= s_axis_tdata[192 + a*32 +: 32];
            end
            r_tmin <= s_axis_tdata[319:288];
            if (w_cmd == CMD_START) begin
                r_res_st  <= ST_NO_GRID;
                r_res_idx <= '0;
                r_res_ex  <= '0;
            end else if (!r_walk) begin
                r_res_st  <= ST_IGNORED;
                r_res_idx <= '0;
                r_res_ex  <= '0;
            end else begin
                // hit repeats the current cell, miss the cell being left
                r_res_st  <= w_is_hit ? ST_HIT : ST_MISS;
                r_res_idx <= r_idx;
                r_res_ex  <= r_exit;
            end
        end
        if (r_state == S_P && w_diff[33]) begin
            // start point below the grid clamps to the first cell
            r_q <= '0;
        end
        if (r_state == S_DIV && w_drsp.done) begin
            r_q <= (w_drsp.quot >= 32'(w_n_s)) ? 32'(w_n_s) - 32'd1 : w_drsp.quot;
        end
        if (r_state == S_FACE) begin
            r_off <= sat32(w_face);
        end
        if (r_state == S_I2) begin
            r_nxny <= w_mraw[29:0];
        end
        if (r_state == S_I3) begin
            r_acc <= w_mraw[29:0];
        end
        if (r_state == S_I4) begin
            r_res_st  <= ST_VISIT;
            r_res_idx <= 30'(r_pos[0]) + r_acc + w_mraw[29:0];
            r_res_ex  <= w_least;
        end
        if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
            r_out_st  <= r_res_st;
            r_out_idx <= r_res_idx;
            r_out_ex  <= r_res_ex;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_out_ex, r_out_idx};
    assign m_axis_tuser  = r_out_st;

endmodule

`default_nettype wire

>>> rtl/vgrw_checker.sv
// ---------------------------------------------------------------------------
// vgrw_checker
// port level checks of the voxel grid ray walk unit, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "voxel_grid_ray_walk_unit_defines.svh"

module vgrw_checker
    import vgrw_pkg::*;
(
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [63:0]  m_axis_tdata,
    input wire [2:0]   m_axis_tuser
);

    // a stalled result beat holds
    `VGRW_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed under stall")

    // one beat in work at a time
    `VGRW_ASSERT_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a beat is in work")

    // no-grid and ignored answers carry zero index and distance
    `VGRW_ASSERT_NOW(a_idle_zero, m_axis_tvalid && (m_axis_tuser == ST_NO_GRID || m_axis_tuser == ST_IGNORED), m_axis_tdata == 64'd0, "nonzero payload on empty answer")

endmodule

bind voxel_grid_ray_walk_unit vgrw_checker u_vgrw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
